// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue core.
// Used by dq_ctrl, dq_datapath and double_ended_queue_core; no dependencies.
package dq_pkg;

    // Default sizing of the ring
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths on the stream ports
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int DOUT_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed port widths, rounded up to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 8;

    // Operation codes carried in the request
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;

    // Status codes returned with each result
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the incoming request
        logic exec;         // update pointers, write or read the ring
        logic load_direct;  // load a result that needs no ring read
        logic load_read;    // load a result from the registered read word
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_read;    // current request returns a word from the ring
    } t_dp_sts;

endpackage

// ----- rtl/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the double-ended queue core: controller plus datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
// Usage:
//   Each request on the slave stream carries an operation in s_axis_tuser
//   (push front, push back, pop front, pop back, peek front, peek back) and a
//   word in s_axis_tdata. Every request returns exactly one result on the
//   master stream: the popped or peeked word, a status (ok, full, empty) and
//   the number of stored words after the operation.
//   Pushes, rejected requests and unused codes load their result from the
//   access step; pops and peeks load it in a further step from the read
//   word, because the single-port ring memory has a registered read.
//   The controller handles one request at a time and takes no new request
//   until the previous one has loaded its result.
//   A new request is taken while the previous result still waits in the
//   output register. When the receiver stalls, the pending request holds
//   before touching the ring until the output register frees.
//   Reset clears head, count, the controller state and the output valid flag;
//   ring contents are left as they are and are never read before being written.
module double_ended_queue_core #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic [dq_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,   // [2:0] mode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,   // [31:0] data_out, [36:32] count
    output logic [dq_pkg::M_TUSER_W-1:0]  o_m_axis_tuser    // [1:0] status
);

    dq_pkg::t_dp_cmd               w_cmd;
    dq_pkg::t_dp_sts               w_sts;
    logic [dq_pkg::DOUT_W-1:0]     w_data;
    logic [dq_pkg::STATUS_W-1:0]   w_status;
    logic [dq_pkg::COUNT_W-1:0]    w_count;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_mode   (i_s_axis_tuser[dq_pkg::MODE_W-1:0]),
        .i_value  (i_s_axis_tdata[dq_pkg::VALUE_W-1:0]),
        .o_data   (w_data),
        .o_status (w_status),
        .o_count  (w_count)
    );

    // Pack the result, padding to whole bytes
    assign o_m_axis_tdata = {
        {(dq_pkg::M_TDATA_W - dq_pkg::DOUT_W - dq_pkg::COUNT_W){1'b0}}, w_count, w_data
    };
    assign o_m_axis_tuser = {{(dq_pkg::M_TUSER_W - dq_pkg::STATUS_W){1'b0}}, w_status};

endmodule

// ----- rtl/dq_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing controller for the double-ended queue core.
// Depends on dq_pkg for the command and status structs.
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  dq_pkg::t_dp_sts i_sts,
    output dq_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, commands and output valid
    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid && !i_out_ready;
        o_cmd.capture     = 1'b0;
        o_cmd.exec        = 1'b0;
        o_cmd.load_direct = 1'b0;
        o_cmd.load_read   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.need_read) begin
                        n_state = S_READ;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                        n_out_valid       = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Ring access only while the output register is free
    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> w_out_free)
        else $error("ring access issued while result still pending");

    // Read wait always follows an access cycle
    a_read_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && o_cmd.exec && i_sts.need_read) |=> (r_state == S_READ))
        else $error("read result step did not follow ring read");

    // Never overwrite an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_cmd.load_direct || o_cmd.load_read) && r_out_valid) |-> i_out_ready)
        else $error("result register overwritten before it was taken");

endmodule

// ----- rtl/dq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the double-ended queue core: ring memory, head and count, result register.
// Depends on dq_pkg for codes, field widths and the command and status structs.
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dq_pkg::t_dp_cmd               i_cmd,
    output dq_pkg::t_dp_sts               o_sts,
    input  logic [dq_pkg::MODE_W-1:0]     i_mode,
    input  logic [dq_pkg::VALUE_W-1:0]    i_value,
    output logic [dq_pkg::DOUT_W-1:0]     o_data,
    output logic [dq_pkg::STATUS_W-1:0]   o_status,
    output logic [dq_pkg::COUNT_W-1:0]    o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Captured request
    logic [dq_pkg::MODE_W-1:0]   r_mode;
    logic [DATA_WIDTH-1:0]       r_word;

    // Ring state
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               n_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [DATA_WIDTH-1:0]       r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]       r_rd_data;

    // Result register
    logic [dq_pkg::DOUT_W-1:0]   r_out_data;
    logic [dq_pkg::STATUS_W-1:0] r_out_status;
    logic [dq_pkg::COUNT_W-1:0]  r_out_count;

    // Decode and address logic
    logic                        w_full;
    logic                        w_empty;
    logic                        w_is_push;
    logic [SW-1:0]               w_tail_sum;
    logic [SW-1:0]               w_tail_pos;
    logic [SW-1:0]               w_last_sum;
    logic [SW-1:0]               w_last_pos;
    logic [AW-1:0]               w_head_dec;
    logic [AW-1:0]               w_head_inc;
    logic [AW-1:0]               w_addr;
    logic                        w_we;
    logic                        w_re;
    logic                        w_need_read;
    logic [dq_pkg::STATUS_W-1:0] w_status;

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_is_push = (r_mode == dq_pkg::MODE_PUSH_FRONT)
                    || (r_mode == dq_pkg::MODE_PUSH_BACK);

    // Slot past the back, and slot of the back element, wrapped once
    assign w_tail_sum = SW'(r_head) + SW'(r_count);
    assign w_tail_pos = (w_tail_sum >= SW'(DEPTH)) ? w_tail_sum - SW'(DEPTH) : w_tail_sum;
    assign w_last_sum = w_tail_sum - SW'(1);
    assign w_last_pos = (w_last_sum >= SW'(DEPTH)) ? w_last_sum - SW'(DEPTH) : w_last_sum;

    // Head step in either direction
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Operation decode
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        w_addr      = r_head;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_need_read = 1'b0;
        w_status    = dq_pkg::ST_OK;
        unique case (r_mode)
            dq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = dq_pkg::ST_FULL;
                end else begin
                    n_head  = w_head_dec;
                    w_addr  = w_head_dec;
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::MODE_PUSH_BACK: begin
                if (w_full) begin
                    w_status = dq_pkg::ST_FULL;
                end else begin
                    w_addr  = w_tail_pos[AW-1:0];
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::MODE_POP_FRONT: begin
                if (w_empty) begin
                    w_status = dq_pkg::ST_EMPTY;
                end else begin
                    w_re        = 1'b1;
                    w_need_read = 1'b1;
                    n_head      = w_head_inc;
                    n_count     = r_count - 1'b1;
                end
            end
            dq_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    w_status = dq_pkg::ST_EMPTY;
                end else begin
                    w_addr      = w_last_pos[AW-1:0];
                    w_re        = 1'b1;
                    w_need_read = 1'b1;
                    n_count     = r_count - 1'b1;
                end
            end
            dq_pkg::MODE_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = dq_pkg::ST_EMPTY;
                end else begin
                    w_re        = 1'b1;
                    w_need_read = 1'b1;
                end
            end
            dq_pkg::MODE_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = dq_pkg::ST_EMPTY;
                end else begin
                    w_addr      = w_last_pos[AW-1:0];
                    w_re        = 1'b1;
                    w_need_read = 1'b1;
                end
            end
            default: begin
                // unused codes leave the ring alone
            end
        endcase
    end

    assign o_sts.need_read = w_need_read;

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_word <= DATA_WIDTH'(i_value);
        end
    end

    // Advance head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Ring memory, single port with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_word;
        end
        if (i_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_out_data   <= '0;
            r_out_status <= w_status;
            r_out_count  <= dq_pkg::COUNT_W'(n_count);
        end else if (i_cmd.load_read) begin
            r_out_data   <= dq_pkg::DOUT_W'(r_rd_data);
            r_out_status <= dq_pkg::ST_OK;
            r_out_count  <= dq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_data   = r_out_data;
    assign o_status = r_out_status;
    assign o_count  = r_out_count;

    // Fill count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond ring depth");

    // Accepted push grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_is_push && !w_full) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("push did not advance the fill count");

    // Read-backed results only follow an accepted read
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_read |-> $past(i_cmd.exec && w_re))
        else $error("ring word returned without a read");

endmodule
